>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the decryptor modules. They compile
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define P64DEC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define P64DEC_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`else

`define P64DEC_ASSERT(label, clk, rst, prop, msg)
`define P64DEC_ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

>>> rtl/p64dec_pkg.sv
// ----------------------------------------------------------------------------
// PRESENT-64 decryptor package
// Widths, register indexes, controller types and the S-box and permutation
// functions shared by the decryptor modules.
// ----------------------------------------------------------------------------
package p64dec_pkg;

   // Block and key word width.
   localparam int unsigned BLOCK_W = 64;
   // Width of the configuration register index.
   localparam int unsigned CSR_IDX_W = 2;
   // Default number of decryption rounds.
   localparam int unsigned NUM_ROUNDS_DEF = 31;
   // Width of the round number fed to the key schedule.
   localparam int unsigned RND_W = 6;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 2'd2;

   // Key size mode codes.
   localparam logic MODE_KEY80  = 1'b0;
   localparam logic MODE_KEY128 = 1'b1;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_START,
      ST_DECRYPT,
      ST_FINAL
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic block_load;
      logic key_load;
      logic key_step;
      logic round_step;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } stat_type;

   // Forward S-box, used by the key schedule.
   function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
      logic [3:0] y;
      unique case (x)
         4'h0: y = 4'hC;
         4'h1: y = 4'h5;
         4'h2: y = 4'h6;
         4'h3: y = 4'hB;
         4'h4: y = 4'h9;
         4'h5: y = 4'h0;
         4'h6: y = 4'hA;
         4'h7: y = 4'hD;
         4'h8: y = 4'h3;
         4'h9: y = 4'hE;
         4'hA: y = 4'hF;
         4'hB: y = 4'h8;
         4'hC: y = 4'h4;
         4'hD: y = 4'h7;
         4'hE: y = 4'h1;
         default: y = 4'h2;
      endcase
      return y;
   endfunction

   // Inverse S-box, used by the decryption rounds.
   function automatic logic [3:0] sbox_inv(input logic [3:0] x);
      logic [3:0] y;
      unique case (x)
         4'h0: y = 4'h5;
         4'h1: y = 4'hE;
         4'h2: y = 4'hF;
         4'h3: y = 4'h8;
         4'h4: y = 4'hC;
         4'h5: y = 4'h1;
         4'h6: y = 4'h2;
         4'h7: y = 4'hD;
         4'h8: y = 4'hB;
         4'h9: y = 4'h4;
         4'hA: y = 4'h6;
         4'hB: y = 4'h3;
         4'hC: y = 4'h0;
         4'hD: y = 4'h7;
         4'hE: y = 4'h9;
         default: y = 4'hA;
      endcase
      return y;
   endfunction

   // Inverse bit permutation: bit k moves to 4k mod 63, the top bit stays.
   // This is pure wiring.
   function automatic logic [BLOCK_W-1:0] inv_perm(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] res;
      res = '0;
      for (int k = 0; k < BLOCK_W - 1; k++) begin
         res[(4 * k) % (BLOCK_W - 1)] = s[k];
      end
      res[BLOCK_W-1] = s[BLOCK_W-1];
      return res;
   endfunction

   // Inverse S-box on all sixteen nibbles.
   function automatic logic [BLOCK_W-1:0] inv_sub(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] res;
      res = '0;
      for (int n = 0; n < BLOCK_W / 4; n++) begin
         res[4*n +: 4] = sbox_inv(s[4*n +: 4]);
      end
      return res;
   endfunction

endpackage

>>> rtl/p64dec_ifs.sv
// ----------------------------------------------------------------------------
// PRESENT-64 decryptor channel interfaces
// Valid/ready interfaces for the ciphertext request and plaintext response
// channels.
// ----------------------------------------------------------------------------

// Ciphertext request channel.
interface p64dec_req_if;
   import p64dec_pkg::*;

   logic               valid;
   logic               ready;
   logic [BLOCK_W-1:0] cipher_block;

   modport source (output valid, output cipher_block, input ready);
   modport sink (input valid, input cipher_block, output ready);
endinterface

// Plaintext response channel.
interface p64dec_rsp_if;
   import p64dec_pkg::*;

   logic               valid;
   logic               ready;
   logic [BLOCK_W-1:0] plain_block;

   modport source (output valid, output plain_block, input ready);
   modport sink (input valid, input plain_block, output ready);
endinterface

>>> rtl/p64dec_ctrl.sv
// ----------------------------------------------------------------------------
// PRESENT-64 decryptor controller
// Sequences key expansion, the decryption rounds and the hand-off of the
// result to the output register. Holds the round counter and the flag that
// marks the round key table as up to date.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module p64dec_ctrl #(
   parameter int unsigned NUM_ROUNDS = p64dec_pkg::NUM_ROUNDS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                csr_we,
   input  logic [p64dec_pkg::CSR_IDX_W-1:0]    csr_index,
   input  p64dec_pkg::stat_type                stat,
   output p64dec_pkg::cmd_type                 cmd,
   output logic [$clog2(NUM_ROUNDS + 1)-1:0]   tbl_idx
);
   import p64dec_pkg::*;

   localparam int unsigned IDX_W = $clog2(NUM_ROUNDS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ROUNDS);
   localparam logic [IDX_W-1:0] ONE_IDX = IDX_W'(1);

   state_type        state_ff;
   state_type        state_in;
   logic [IDX_W-1:0] cnt_ff;
   logic [IDX_W-1:0] cnt_in;
   logic             keys_ready_ff;
   logic             keys_ready_in;
   logic             req_fire;
   logic             csr_hit;

   assign req_fire = req_valid && req_ready;
   assign csr_hit = csr_we && ((csr_index == CSR_KEY_MODE) || (csr_index == CSR_KEY_LOW)
                               || (csr_index == CSR_KEY_HIGH));

   // Next state and round counter.
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (keys_ready_ff) begin
                  state_in = ST_DECRYPT;
                  cnt_in = LAST_IDX;
               end else begin
                  state_in = ST_EXPAND;
                  cnt_in = '0;
               end
            end
         end
         ST_EXPAND: begin
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_START;
            end else begin
               cnt_in = cnt_ff + ONE_IDX;
            end
         end
         ST_START: begin
            state_in = ST_DECRYPT;
            cnt_in = LAST_IDX;
         end
         ST_DECRYPT: begin
            if (cnt_ff == ONE_IDX) begin
               state_in = ST_FINAL;
            end else begin
               cnt_in = cnt_ff - ONE_IDX;
            end
         end
         ST_FINAL: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands and table address for the current state.
   always_comb begin
      cmd = '0;
      tbl_idx = LAST_IDX;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // The table is read at the last round key while waiting, so the
            // first round can start right after the transaction.
            req_ready = 1'b1;
            cmd.block_load = req_valid;
            cmd.key_load = req_valid && !keys_ready_ff;
         end
         ST_EXPAND: begin
            cmd.key_step = 1'b1;
            tbl_idx = cnt_ff;
         end
         ST_START: begin
            tbl_idx = LAST_IDX;
         end
         ST_DECRYPT: begin
            cmd.round_step = 1'b1;
            tbl_idx = cnt_ff - ONE_IDX;
         end
         ST_FINAL: begin
            cmd.out_load = stat.out_free;
            tbl_idx = '0;
         end
         default: begin
            tbl_idx = LAST_IDX;
         end
      endcase
   end

   // Key table flag: a register write wins over the end of an expansion.
   always_comb begin
      keys_ready_in = keys_ready_ff;
      if (csr_hit) begin
         keys_ready_in = 1'b0;
      end else if ((state_ff == ST_EXPAND) && (cnt_ff == LAST_IDX)) begin
         keys_ready_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         keys_ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         keys_ready_ff <= keys_ready_in;
      end
   end

   `P64DEC_ASSERT(a_key_write_clears, clock, reset, csr_hit |=> !keys_ready_ff, "key write did not clear the ready flag")
   `P64DEC_ASSERT_NEVER(a_decrypt_cnt, clock, reset, (state_ff == ST_DECRYPT) && (cnt_ff == '0), "decrypt round counter at zero")
   `P64DEC_ASSERT(a_final_after_round1, clock, reset, ((state_ff == ST_FINAL) && ($past(state_ff) == ST_DECRYPT)) |-> ($past(cnt_ff) == ONE_IDX), "final key XOR reached before round one")
   `P64DEC_ASSERT(a_accept_starts, clock, reset, req_fire |=> ((state_ff == ST_DECRYPT) || (state_ff == ST_EXPAND)), "accepted transaction did not start work")

endmodule

>>> rtl/p64dec_dp.sv
// ----------------------------------------------------------------------------
// PRESENT-64 decryptor datapath
// Key registers, key schedule, round key memory, the cipher state with one
// inverse round, and the output register of the response channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module p64dec_dp #(
   parameter int unsigned NUM_ROUNDS = p64dec_pkg::NUM_ROUNDS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  p64dec_pkg::cmd_type                 cmd,
   input  logic [$clog2(NUM_ROUNDS + 1)-1:0]   tbl_idx,
   input  logic                                csr_we,
   input  logic [p64dec_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [p64dec_pkg::BLOCK_W-1:0]      csr_wdata,
   input  logic [p64dec_pkg::BLOCK_W-1:0]      cipher_block,
   output p64dec_pkg::stat_type                stat,
   p64dec_rsp_if.source                        rsp_chan
);
   import p64dec_pkg::*;

   localparam int unsigned DEPTH = NUM_ROUNDS + 1;

   logic                 key_mode_ff;
   logic [BLOCK_W-1:0]   key_low_ff;
   logic [BLOCK_W-1:0]   key_high_ff;
   logic [BLOCK_W-1:0]   ks_hi_ff;
   logic [BLOCK_W-1:0]   ks_hi_in;
   logic [BLOCK_W-1:0]   ks_lo_ff;
   logic [BLOCK_W-1:0]   ks_lo_in;
   logic [BLOCK_W-1:0]   rk_mem [DEPTH];
   logic [BLOCK_W-1:0]   rk_rd_ff;
   logic [BLOCK_W-1:0]   state_ff;
   logic [BLOCK_W-1:0]   state_in;
   logic [BLOCK_W-1:0]   plain_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic [RND_W-1:0]     rnd;
   logic [BLOCK_W-1:0]   h80;
   logic [BLOCK_W-1:0]   l80;
   logic [BLOCK_W-1:0]   h128;
   logic [BLOCK_W-1:0]   l128;
   logic [4:0]           ctr128;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_mode_ff <= MODE_KEY80;
         key_low_ff <= '0;
         key_high_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_MODE: key_mode_ff <= csr_wdata[0];
            CSR_KEY_LOW: key_low_ff <= csr_wdata;
            CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            default: key_mode_ff <= key_mode_ff;
         endcase
      end
   end

   // One key schedule step; the round number is the next table index.
   always_comb begin
      rnd = RND_W'(tbl_idx) + RND_W'(1);

      // 80-bit schedule: hi holds key bits 79..16, lo holds bits 15..0.
      h80 = {ks_hi_ff[2:0], ks_lo_ff[15:0], ks_hi_ff[BLOCK_W-1:19]};
      h80[63:60] = sbox_fwd(h80[63:60]);
      h80[RND_W-2:0] = h80[RND_W-2:0] ^ rnd[RND_W-1:1];
      l80 = {48'd0, ks_hi_ff[18:3] ^ {rnd[0], 15'd0}};

      // 128-bit schedule: counter lands on key bits 66..62.
      h128 = {ks_hi_ff[2:0], ks_lo_ff[BLOCK_W-1:3]};
      l128 = {ks_lo_ff[2:0], ks_hi_ff[BLOCK_W-1:3]};
      h128[63:60] = sbox_fwd(h128[63:60]);
      h128[59:56] = sbox_fwd(h128[59:56]);
      ctr128 = {h128[2:0], l128[63:62]} ^ rnd[4:0];
      h128[2:0] = ctr128[4:2];
      l128[63:62] = ctr128[1:0];
   end

   // Key schedule registers.
   always_comb begin
      ks_hi_in = ks_hi_ff;
      ks_lo_in = ks_lo_ff;
      if (cmd.key_load) begin
         if (key_mode_ff == MODE_KEY128) begin
            ks_hi_in = key_high_ff;
            ks_lo_in = key_low_ff;
         end else begin
            ks_hi_in = {key_high_ff[15:0], key_low_ff[BLOCK_W-1:16]};
            ks_lo_in = {48'd0, key_low_ff[15:0]};
         end
      end else if (cmd.key_step) begin
         if (key_mode_ff == MODE_KEY128) begin
            ks_hi_in = h128;
            ks_lo_in = l128;
         end else begin
            ks_hi_in = h80;
            ks_lo_in = l80;
         end
      end
   end

   always_ff @(posedge clock) begin
      ks_hi_ff <= ks_hi_in;
      ks_lo_ff <= ks_lo_in;
   end

   // Round key memory: one write port for expansion, one registered read.
   always_ff @(posedge clock) begin
      if (cmd.key_step) begin
         rk_mem[tbl_idx] <= ks_hi_ff;
      end
      rk_rd_ff <= rk_mem[tbl_idx];
   end

   // Cipher state: load a block, or run one inverse round.
   always_comb begin
      state_in = state_ff;
      if (cmd.block_load) begin
         state_in = cipher_block;
      end else if (cmd.round_step) begin
         state_in = inv_sub(inv_perm(state_ff ^ rk_rd_ff));
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   // Output register with the final key XOR.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         plain_ff <= state_ff ^ rk_rd_ff;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.plain_block = plain_ff;
   assign stat.out_free = !out_valid_ff || rsp_chan.ready;

   `P64DEC_ASSERT(a_cmd_exclusive, clock, reset, $onehot0({cmd.key_load, cmd.key_step, cmd.round_step, cmd.out_load}), "conflicting datapath commands")
   `P64DEC_ASSERT(a_no_overwrite, clock, reset, cmd.out_load |-> (!out_valid_ff || rsp_chan.ready), "pending result overwritten")
   `P64DEC_ASSERT(a_valid_from_load, clock, reset, $rose(out_valid_ff) |-> $past(cmd.out_load), "result shown without a load")

endmodule

>>> rtl/present64_block_decryptor_core.sv
// ----------------------------------------------------------------------------
// PRESENT-64 block decryptor core
// Decrypts one 64-bit ciphertext block per transaction with the 80-bit or
// 128-bit PRESENT key schedule.
//
// Usage:
//  - req_chan carries the ciphertext block, rsp_chan the plaintext block;
//    both use a valid/ready handshake, one response per request.
//  - The csr_ port writes the key mode (index 0), the low key word (index 1)
//    and the high key word (index 2). Any such write marks the round key
//    table stale; write only while the core is idle.
//  - The first block after a key write first expands the round key table,
//    one round key per cycle for NUM_ROUNDS + 1 round keys, then restarts
//    the table read in a start state.
//  - A block then runs NUM_ROUNDS rounds (one round per cycle, set by the
//    single round unit and the one read port of the key memory), then the
//    final key XOR into the output register. The controller passes through
//    its idle state between blocks, so it takes a new block only once the
//    last one is through its final key XOR.
//  - The response sits in an output register; the next request is taken
//    while it waits. If the receiver stalls, the next block holds in its
//    last step until the output register frees up.
//  - Reset clears the key registers, the ready flag and the handshakes. The
//    key table needs no clearing pass since it is expanded before use.
// ----------------------------------------------------------------------------
module present64_block_decryptor_core #(
   parameter int unsigned NUM_ROUNDS = p64dec_pkg::NUM_ROUNDS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   p64dec_req_if.sink                          req_chan,
   p64dec_rsp_if.source                        rsp_chan,
   input  logic                                csr_we,
   input  logic [p64dec_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [p64dec_pkg::BLOCK_W-1:0]      csr_wdata
);
   import p64dec_pkg::*;

   localparam int unsigned IDX_W = $clog2(NUM_ROUNDS + 1);

   cmd_type          cmd;
   stat_type         stat;
   logic [IDX_W-1:0] tbl_idx;
   logic             req_ready;

   // Sequencer.
   p64dec_ctrl #(
      .NUM_ROUNDS(NUM_ROUNDS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .stat      (stat),
      .cmd       (cmd),
      .tbl_idx   (tbl_idx)
   );

   assign req_chan.ready = req_ready;

   // Key schedule, round unit and output register.
   p64dec_dp #(
      .NUM_ROUNDS(NUM_ROUNDS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .tbl_idx      (tbl_idx),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cipher_block (req_chan.cipher_block),
      .stat         (stat),
      .rsp_chan     (rsp_chan)
   );

endmodule
